>>> design/lzbd_pkg.sv
// Package for the LZ block decompressor: sizes, token phase codes,
// controller/datapath command and status structs, and the header length helper.
// Used by the controller, the datapath and the top level.
`default_nettype none
package lzbd_pkg;

	localparam int WINDOW_BITS = 17;
	localparam int WIN_DEPTH = 1 << WINDOW_BITS;
	localparam logic [32:0] WIN_SIZE = 33'd1 << WINDOW_BITS;

	localparam logic [2:0] PH_CWORD = 3'd0;
	localparam logic [2:0] PH_TOKEN = 3'd1;
	localparam logic [2:0] PH_MATCH = 3'd2;
	localparam logic [2:0] PH_TAIL  = 3'd3;
	localparam logic [2:0] PH_ENDED = 3'd4;

	typedef struct packed {
		logic load;
		logic decode;
		logic rd;
		logic wr;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic ignore;
		logic dec_push;
		logic dec_match;
		logic push_ok;
		logic copy_more;
		logic flush_needed;
		logic out_free;
	} sts_t;

	// Number of match header bytes implied by the first header byte.
	function automatic logic [2:0] hdr_len(input logic [7:0] first);
		logic [2:0] n;
		if (first[1:0] == 2'b00) begin
			n = 3'd1;
		end else if (first[1:0] != 2'b11) begin
			n = 3'd2;
		end else if (first[6:0] != 7'h03) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

endpackage
`default_nettype wire

>>> design/lzbd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module lzbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/lzbd_ctrl.sv
// Controller state machine of the LZ block decompressor.
// Depends on lzbd_pkg; drives commands to lzbd_dp from its status.
`default_nettype none
module lzbd_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_stall,
	input  wire lzbd_pkg::sts_t sts,
	output lzbd_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_COPY_RD = 3'd2;
	localparam logic [2:0] S_COPY_WR = 3'd3;
	localparam logic [2:0] S_FINISH  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.ignore) begin
					state_d = S_IDLE;
				end else if (!sts.dec_push || sts.push_ok) begin
					cmd.decode = 1'b1;
					state_d = sts.dec_match ? S_COPY_RD : S_FINISH;
				end
			end
			S_COPY_RD: begin
				if (sts.copy_more) begin
					cmd.rd = 1'b1;
					state_d = S_COPY_WR;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_COPY_WR: begin
				if (sts.push_ok) begin
					cmd.wr = 1'b1;
					state_d = S_COPY_RD;
				end
			end
			S_FINISH: begin
				if (!sts.flush_needed) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> design/lzbd_dp.sv
// Datapath of the LZ block decompressor: token decode, match copy through the
// history RAM, output packing and the result register. Depends on lzbd_pkg, lzbd_ram.
`default_nettype none
module lzbd_dp (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [7:0]   compressed_byte,
	input  wire logic         last_input,
	input  wire logic         cfg_valid,
	input  wire logic [31:0]  output_size,
	output logic              result_valid,
	input  wire logic         result_stall,
	output logic [63:0]       out_bytes,
	output logic [3:0]        byte_count,
	output logic              block_done,
	output logic              short_input,
	input  wire lzbd_pkg::cmd_t cmd,
	output lzbd_pkg::sts_t    sts
);

	logic [7:0]  byte_q;
	logic        last_q;
	logic [31:0] osize_q;
	logic [31:0] cw_q;
	logic [31:0] look_q;
	logic [2:0]  lfill_q;
	logic [31:0] pos_q;
	logic [2:0]  phase_q;
	logic [8:0]  rem_q;
	logic [16:0] src_q;
	logic        badsrc_q;
	logic [63:0] acc_q;
	logic [3:0]  afill_q;
	logic        res_valid_q;
	logic [63:0] res_bytes_q;
	logic [3:0]  res_count_q;
	logic        res_done_q;
	logic        res_short_q;

	logic [2:0]  eff_ph;
	logic [31:0] cw_d;
	logic [31:0] look_d;
	logic [2:0]  lfill_d;
	logic [2:0]  phase_d;
	logic [2:0]  nf;
	logic [31:0] shift_look;
	logic [31:0] mword;
	logic        dec_push;
	logic        match_go;
	logic [8:0]  m_len;
	logic [16:0] m_dist;
	logic        push_en;
	logic [7:0]  push_data;
	logic [7:0]  rdata;
	logic [31:0] src_diff;
	logic        src_ok;
	logic        done_now;
	logic        short_now;

	always_comb begin
		eff_ph = (phase_q == lzbd_pkg::PH_TOKEN && cw_q == 32'd1) ? lzbd_pkg::PH_CWORD : phase_q;
		shift_look = look_q | ({24'd0, byte_q} << {lfill_q[1:0], 3'b000});
		nf = lfill_q + 3'd1;
		cw_d = cw_q;
		look_d = look_q;
		lfill_d = lfill_q;
		phase_d = eff_ph;
		dec_push = 1'b0;
		match_go = 1'b0;
		mword = shift_look;
		case (eff_ph)
			lzbd_pkg::PH_CWORD: begin
				if (lfill_q[1:0] == 2'd3) begin
					cw_d = shift_look;
					look_d = '0;
					lfill_d = '0;
					phase_d = lzbd_pkg::PH_TOKEN;
				end else begin
					look_d = shift_look;
					lfill_d = nf;
				end
			end
			lzbd_pkg::PH_TOKEN: begin
				cw_d = cw_q >> 1;
				if (cw_q[0]) begin
					if (lzbd_pkg::hdr_len(byte_q) == 3'd1) begin
						match_go = 1'b1;
						mword = {24'd0, byte_q};
					end else begin
						look_d = {24'd0, byte_q};
						lfill_d = 3'd1;
						phase_d = lzbd_pkg::PH_MATCH;
					end
				end else begin
					dec_push = 1'b1;
					if ({1'b0, pos_q} + 33'd10 >= {1'b0, osize_q}) begin
						phase_d = lzbd_pkg::PH_TAIL;
					end
				end
			end
			lzbd_pkg::PH_MATCH: begin
				if (nf >= lzbd_pkg::hdr_len(shift_look[7:0])) begin
					match_go = 1'b1;
					look_d = '0;
					lfill_d = '0;
					phase_d = lzbd_pkg::PH_TOKEN;
				end else begin
					look_d = shift_look;
					lfill_d = nf;
				end
			end
			lzbd_pkg::PH_TAIL: begin
				if (cw_q == 32'd1) begin
					if (nf >= 3'd4) begin
						lfill_d = '0;
						cw_d = 32'h8000_0000;
					end else begin
						lfill_d = nf;
					end
				end else begin
					dec_push = 1'b1;
					cw_d = cw_q >> 1;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Match distance and length for the five header encodings.
	always_comb begin
		if (mword[1:0] == 2'b00) begin
			m_dist = {11'd0, mword[7:2]};
			m_len = 9'd3;
		end else if (!mword[1]) begin
			m_dist = {3'd0, mword[15:2]};
			m_len = 9'd3;
		end else if (!mword[0]) begin
			m_dist = {7'd0, mword[15:6]};
			m_len = {5'd0, mword[5:2]} + 9'd3;
		end else if (mword[6:0] != 7'h03) begin
			m_dist = mword[23:7];
			m_len = {4'd0, mword[6:2]} + 9'd2;
		end else begin
			m_dist = mword[31:15];
			m_len = {1'b0, mword[14:7]} + 9'd3;
		end
	end

	assign src_diff = pos_q - {15'd0, src_q};
	assign src_ok = (src_q != 17'd0) && ({15'd0, src_q} <= pos_q) &&
		({16'd0, src_q} <= lzbd_pkg::WIN_SIZE);

	assign push_en = (cmd.decode && dec_push) || cmd.wr;
	assign push_data = cmd.wr ? (badsrc_q ? 8'd0 : rdata) : byte_q;

	assign done_now = (pos_q >= osize_q);
	assign short_now = last_q && !done_now;

	assign sts.ignore = (phase_q == lzbd_pkg::PH_ENDED) || done_now;
	assign sts.dec_push = dec_push;
	assign sts.dec_match = match_go;
	assign sts.push_ok = (afill_q != 4'd8) || !res_valid_q;
	assign sts.copy_more = (rem_q != 9'd0) && !done_now;
	assign sts.flush_needed = (afill_q != 4'd0) || short_now;
	assign sts.out_free = !res_valid_q;

	lzbd_ram #(
		.WIDTH(8),
		.DEPTH(lzbd_pkg::WIN_DEPTH)
	) u_hist (
		.clk    (clk),
		.we     (push_en),
		.waddr  (pos_q[lzbd_pkg::WINDOW_BITS-1:0]),
		.wdata  (push_data),
		.re     (cmd.rd),
		.raddr  (src_diff[lzbd_pkg::WINDOW_BITS-1:0]),
		.rdata_q(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osize_q <= '0;
			cw_q <= 32'd1;
			look_q <= '0;
			lfill_q <= '0;
			pos_q <= '0;
			phase_q <= lzbd_pkg::PH_CWORD;
			rem_q <= '0;
			src_q <= '0;
			badsrc_q <= 1'b0;
			acc_q <= '0;
			afill_q <= '0;
			res_valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				osize_q <= output_size;
			end
			if (cmd.load) begin
				last_q <= last_input;
			end
			if (cmd.decode) begin
				cw_q <= cw_d;
				look_q <= look_d;
				lfill_q <= lfill_d;
				phase_q <= phase_d;
				if (match_go) begin
					src_q <= m_dist;
					rem_q <= m_len;
				end
			end
			if (cmd.rd) begin
				badsrc_q <= !src_ok;
			end
			if (cmd.wr) begin
				rem_q <= rem_q - 9'd1;
			end
			if (result_valid && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (push_en) begin
				pos_q <= pos_q + 32'd1;
				if (afill_q == 4'd8) begin
					res_valid_q <= 1'b1;
					acc_q <= {56'd0, push_data};
					afill_q <= 4'd1;
				end else begin
					acc_q[{afill_q[2:0], 3'b000} +: 8] <= push_data;
					afill_q <= afill_q + 4'd1;
				end
			end
			if (cmd.flush) begin
				res_valid_q <= 1'b1;
				acc_q <= '0;
				afill_q <= '0;
				if (short_now) begin
					phase_q <= lzbd_pkg::PH_ENDED;
				end
			end
		end
	end

	// The result payload is loaded only when the result register is empty.
	always_ff @(posedge clk) begin
		if (push_en && afill_q == 4'd8) begin
			res_bytes_q <= acc_q;
			res_count_q <= 4'd8;
			res_done_q <= 1'b0;
			res_short_q <= 1'b0;
		end else if (cmd.flush) begin
			res_bytes_q <= acc_q;
			res_count_q <= afill_q;
			res_done_q <= done_now;
			res_short_q <= short_now;
		end
	end

	assign result_valid = res_valid_q;
	assign out_bytes = res_bytes_q;
	assign byte_count = res_count_q;
	assign block_done = res_done_q;
	assign short_input = res_short_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= compressed_byte;
		end
	end

endmodule
`default_nettype wire

>>> design/lz_block_decompressor.sv
// Top level of the LZ block decompressor (byte-serial LZ block streams).
// Depends on lzbd_pkg, lzbd_ctrl, lzbd_dp and lzbd_ram.
//
// Usage:
// Compressed bytes enter on the item channel (item_valid, item_stall,
// compressed_byte, last_input); an item is taken when item_valid is high
// and item_stall is low. Decompressed bytes leave on the result channel,
// packed up to eight per item, the first byte in out_bytes[7:0].
// output_size is written over the cfg channel (cfg_ready is always high)
// while the block is idle.
// Sequence: every accepted byte passes the accept, decode and finish states
// (the finish state also flushes any packed result); a byte that arrives
// after the block is done or has ended passes accept and decode only. A match
// adds read and write states per copied byte and a read state to see the end,
// set by the registered read of the history RAM that overlapping copies need.
// While the receiver stalls, packing continues until eight bytes are held and
// another result is due, or a flush is due; the block then holds, item_stall high.
// Reset returns the decoder to expect a control word at output position 0;
// the history RAM is not cleared, since a read of an entry not yet written gives zero.
`default_nettype none
module lz_block_decompressor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  compressed_byte,
	input  wire logic        last_input,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      out_bytes,
	output logic [3:0]       byte_count,
	output logic             block_done,
	output logic             short_input,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] output_size
);

	lzbd_pkg::cmd_t cmd;
	lzbd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	lzbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lzbd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.compressed_byte(compressed_byte),
		.last_input     (last_input),
		.cfg_valid      (cfg_valid),
		.output_size    (output_size),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_bytes      (out_bytes),
		.byte_count     (byte_count),
		.block_done     (block_done),
		.short_input    (short_input),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule
`default_nettype wire

>>> design/lzbd_checker.sv
// Port-level checker for the LZ block decompressor, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module lzbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [63:0] out_bytes,
	input wire logic [3:0]  byte_count,
	input wire logic        block_done,
	input wire logic        short_input
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> byte_count <= 4'd8)
		else $error("byte_count above eight");

	a_done_xor_short: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(block_done && short_input))
		else $error("block_done and short_input together");

	a_empty_only_short: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && byte_count == 4'd0) |-> short_input)
		else $error("empty result without short_input");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(out_bytes)))
		else $error("stalled result changed");

endmodule

bind lz_block_decompressor lzbd_checker u_lzbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.out_bytes   (out_bytes),
	.byte_count  (byte_count),
	.block_done  (block_done),
	.short_input (short_input)
);
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for lz_block_decompressor: a scoreboard class that
// decodes each accepted compressed byte on its own and checks every packed result.
// Depends on lzbd_pkg and the lz_block_decompressor RTL.
`timescale 1ns / 100ps
module tb;

	localparam int LIMIT = 2000000;
	localparam int SETTLE = 40;

	// Token kinds of the stimulus generator.
	localparam int TK_LIT = 0;
	localparam int TK_D6  = 1;
	localparam int TK_D14 = 2;
	localparam int TK_D10 = 3;
	localparam int TK_D17 = 4;
	localparam int TK_L8  = 5;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        done;
		logic        shrt;
	} lz_result_t;

	class lz_scoreboard;
		bit [7:0]   hist [lzbd_pkg::WIN_DEPTH];
		bit [31:0]  cword, look, opos, osize;
		bit [2:0]   fill, phase;
		lz_result_t cur[$];
		lz_result_t expq[$];
		int         errors, nres, ncopies;

		function new();
			cword = 32'd1;
			look = 0;
			fill = 0;
			opos = 0;
			osize = 0;
			phase = lzbd_pkg::PH_CWORD;
			errors = 0;
			nres = 0;
			ncopies = 0;
		endfunction

		function bit [2:0] hdr_bytes(bit [7:0] f);
			if (f[1:0] == 2'b00) begin
				return 3'd1;
			end else if (f[1:0] != 2'b11) begin
				return 3'd2;
			end else if (f[6:0] != 7'h03) begin
				return 3'd3;
			end
			return 3'd4;
		endfunction

		function void put_byte(bit [7:0] b);
			lz_result_t r;
			hist[opos[lzbd_pkg::WINDOW_BITS-1:0]] = b;
			opos++;
			if (cur.size() == 0 || cur[cur.size()-1].cnt == 4'd8) begin
				r = '0;
				cur.push_back(r);
			end
			r = cur.pop_back();
			r.data[8*r.cnt +: 8] = b;
			r.cnt++;
			cur.push_back(r);
		endfunction

		// Byte-by-byte copy, so an overlapping source sees bytes written by this copy.
		function void run_copy(bit [31:0] f);
			bit [16:0] mdist;
			int        len;
			bit [7:0]  b;
			bit [31:0] src;
			if (f[1:0] == 2'b00) begin
				mdist = {11'b0, f[7:2]};
				len = 3;
			end else if (f[1] == 1'b0) begin
				mdist = {3'b0, f[15:2]};
				len = 3;
			end else if (f[0] == 1'b0) begin
				mdist = {7'b0, f[15:6]};
				len = int'(f[5:2]) + 3;
			end else if (f[6:0] != 7'h03) begin
				mdist = f[23:7];
				len = int'(f[6:2]) + 2;
			end else begin
				mdist = f[31:15];
				len = int'(f[14:7]) + 3;
			end
			ncopies++;
			while (len > 0 && opos < osize) begin
				b = 8'h00;
				if (mdist != 0 && {15'b0, mdist} <= opos) begin
					src = opos - {15'b0, mdist};
					b = hist[src[lzbd_pkg::WINDOW_BITS-1:0]];
				end
				put_byte(b);
				len--;
			end
		endfunction

		function void note_input(bit [7:0] b, bit last);
			bit [31:0]  f;
			lz_result_t r;
			if (phase == lzbd_pkg::PH_ENDED || opos >= osize)
				return;
			cur.delete();
			if (phase == lzbd_pkg::PH_TOKEN && cword == 32'd1)
				phase = lzbd_pkg::PH_CWORD;
			case (phase)
				lzbd_pkg::PH_CWORD: begin
					look |= {24'b0, b} << (8 * fill);
					fill++;
					if (fill >= 3'd4) begin
						cword = look;
						look = 0;
						fill = 0;
						phase = lzbd_pkg::PH_TOKEN;
					end
				end
				lzbd_pkg::PH_TOKEN: begin
					if (cword[0]) begin
						cword >>= 1;
						if (hdr_bytes(b) == 3'd1) begin
							run_copy({24'b0, b});
						end else begin
							look = {24'b0, b};
							fill = 3'd1;
							phase = lzbd_pkg::PH_MATCH;
						end
					end else begin
						if ({32'b0, opos} + 64'd10 >= {32'b0, osize})
							phase = lzbd_pkg::PH_TAIL;
						put_byte(b);
						cword >>= 1;
					end
				end
				lzbd_pkg::PH_MATCH: begin
					look |= {24'b0, b} << (8 * fill[1:0]);
					fill++;
					if (fill >= hdr_bytes(look[7:0])) begin
						f = look;
						look = 0;
						fill = 0;
						phase = lzbd_pkg::PH_TOKEN;
						run_copy(f);
					end
				end
				lzbd_pkg::PH_TAIL: begin
					// In tail mode an exhausted control word skips the next four bytes.
					if (cword == 32'd1) begin
						fill++;
						if (fill >= 3'd4) begin
							fill = 0;
							cword = 32'h8000_0000;
						end
					end else begin
						put_byte(b);
						cword >>= 1;
					end
				end
				default: ;
			endcase
			if (opos >= osize) begin
				if (cur.size() > 0) begin
					r = cur.pop_back();
					r.done = 1'b1;
					cur.push_back(r);
				end
			end else if (last) begin
				if (cur.size() == 0) begin
					r = '0;
					cur.push_back(r);
				end
				r = cur.pop_back();
				r.shrt = 1'b1;
				cur.push_back(r);
				phase = lzbd_pkg::PH_ENDED;
			end
			foreach (cur[i])
				expq.push_back(cur[i]);
		endfunction

		function void check_result(lz_result_t got);
			lz_result_t want;
			nres++;
			if (expq.size() == 0) begin
				errors++;
				$display("%0t: unexpected result data=%h count=%0d done=%b short=%b",
					$time, got.data, got.cnt, got.done, got.shrt);
				return;
			end
			want = expq.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: mismatch expected data=%h count=%0d done=%b short=%b",
					$time, want.data, want.cnt, want.done, want.shrt);
				$display("%0t:          actual   data=%h count=%0d done=%b short=%b",
					$time, got.data, got.cnt, got.done, got.shrt);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [7:0]  compressed_byte;
	logic        last_input;
	logic        result_valid;
	logic        result_stall;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        block_done;
	logic        short_input;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] output_size;

	lz_scoreboard sb;
	bit [7:0]     stream_q[$];
	bit [7:0]     token_q[$];
	int           burst_left;
	int           nitems;
	int           cycles;

	lz_block_decompressor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.compressed_byte(compressed_byte),
		.last_input(last_input),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_bytes(out_bytes),
		.byte_count(byte_count),
		.block_done(block_done),
		.short_input(short_input),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.output_size(output_size)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver stall pattern: quiet, light, heavy and long-run stretches in turn.
	always @(posedge clk) begin
		case (cycles[10:9])
			2'd0: result_stall <= 1'b0;
			2'd1: result_stall <= ($urandom_range(0, 2) == 0);
			2'd2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= (cycles[5:4] == 2'b11);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result({out_bytes, byte_count, block_done, short_input});
	end

	// Appends one token to token_q and returns its control bit.
	function automatic bit add_token(int kind, bit [16:0] mdist, int lf);
		bit [31:0] f;
		int        n;
		case (kind)
			TK_LIT: begin
				token_q.push_back(lf[7:0]);
				return 1'b0;
			end
			TK_D6: begin
				f = {24'b0, mdist[5:0], 2'b00};
				n = 1;
			end
			TK_D14: begin
				f = {16'b0, mdist[13:0], 2'b01};
				n = 2;
			end
			TK_D10: begin
				f = {16'b0, mdist[9:0], lf[3:0], 2'b10};
				n = 2;
			end
			TK_D17: begin
				f = {8'b0, mdist, lf[4:0], 2'b11};
				n = 3;
			end
			default: begin
				f = {mdist[16:0], lf[7:0], 7'h03};
				n = 4;
			end
		endcase
		for (int i = 0; i < n; i++)
			token_q.push_back(f[8*i +: 8]);
		return 1'b1;
	endfunction

	function automatic void close_group(bit [31:0] cw);
		for (int i = 0; i < 4; i++)
			stream_q.push_back(cw[8*i +: 8]);
		foreach (token_q[i])
			stream_q.push_back(token_q[i]);
		token_q.delete();
	endfunction

	function automatic void random_group(bit lit_only);
		int        ntok;
		int        kind;
		int        lf;
		bit [31:0] cw;
		bit [16:0] mdist;
		if (!lit_only && $urandom_range(0, 9) == 0) begin
			// Noise: raw bytes that break token alignment.
			repeat ($urandom_range(3, 20))
				stream_q.push_back(8'($urandom));
			return;
		end
		ntok = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 30) : 31;
		cw = 0;
		for (int i = 0; i < ntok; i++) begin
			kind = $urandom_range(0, 9);
			kind = (lit_only || kind < 4 || kind > 8) ? TK_LIT : kind - 3;
			mdist = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(1, 24));
			if (kind == TK_D17)
				lf = $urandom_range(1, 31);
			else if (kind == TK_L8)
				lf = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 24);
			else
				lf = $urandom;
			cw[i] = add_token(kind, mdist, lf);
		end
		cw[ntok] = 1'b1;
		close_group(cw);
	endfunction

	task automatic send_byte(bit [7:0] b, bit l);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0 && item_valid) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		item_valid <= 1'b1;
		compressed_byte <= b;
		last_input <= l;
		do @(posedge clk); while (item_stall);
		sb.note_input(b, l);
		nitems++;
		burst_left--;
	endtask

	task automatic send_stream(bit stop_at_done);
		bit [7:0] b;
		while (stream_q.size() != 0) begin
			if (stop_at_done && sb.opos >= sb.osize)
				break;
			b = stream_q.pop_front();
			send_byte(b, 1'b0);
		end
		stream_q.delete();
	endtask

	// Holds the sender until every expected item is out and the block has settled.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.expq.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(bit [31:0] v);
		cfg_valid <= 1'b1;
		output_size <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.osize = v;
	endtask

	initial begin
		bit unused;
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		compressed_byte = 8'h00;
		last_input = 1'b0;
		cfg_valid = 1'b0;
		output_size = 32'd0;
		result_stall = 1'b0;
		cycles = 0;
		nitems = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero-size block: every byte is dropped, even one marked last.
		write_size(32'd0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hA5, 1'b0);
		drain();

		write_size(32'hFFFF_FFFF);
		// Directed: all five match encodings, extreme distances and lengths,
		// zero and out-of-range distances, overlap, and a stray word of one.
		unused = add_token(TK_LIT, 0, 8'h00);
		unused = add_token(TK_D6, 0, 0);
		unused = add_token(TK_LIT, 0, 8'hFF);
		unused = add_token(TK_LIT, 0, 8'h5A);
		unused = add_token(TK_D6, 2, 0);
		unused = add_token(TK_D14, 17'h3FFF, 0);
		unused = add_token(TK_D10, 1, 15);
		unused = add_token(TK_D17, 17'h1FFFF, 31);
		unused = add_token(TK_D17, 3, 1);
		unused = add_token(TK_L8, 2, 255);
		unused = add_token(TK_L8, 0, 0);
		close_group(32'b1_11111110010);
		close_group(32'd1);
		unused = add_token(TK_LIT, 0, 8'h80);
		unused = add_token(TK_D10, 17'h3FF, 0);
		unused = add_token(TK_L8, 17'h1FFFF, 7);
		close_group(32'b1110);
		send_stream(1'b0);

		while (nitems < 200) begin
			random_group(1'b0);
			send_stream(1'b0);
		end
		drain();
		while (nitems < 330) begin
			random_group(1'b0);
			send_stream(1'b0);
		end
		drain();

		// A long match runs past the end of the block and is cut short.
		write_size(sb.opos + 30);
		unused = add_token(TK_L8, 1, 255);
		close_group(32'b11);
		send_stream(1'b1);
		send_byte(8'($urandom), 1'b0);
		drain();

		// Tail mode: the last bytes are literals and a spent word skips four bytes.
		write_size(sb.opos + 70);
		while (sb.opos < sb.osize) begin
			random_group(1'b1);
			send_stream(1'b1);
		end
		send_byte(8'($urandom), 1'b0);
		drain();

		// Size rewritten below the position: the block counts as done.
		write_size(sb.opos - 1);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
		drain();

		// Input ends before the block is complete; later bytes are dropped.
		write_size(sb.opos + 100);
		repeat (6) send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
		drain();

		$display("Sent %0d compressed bytes; checked %0d result items from %0d match copies.",
			nitems, sb.nres, sb.ncopies);
		$display("Covered empty, cut-off, tail-mode, shrunk and short-input blocks.");
		if (sb.errors == 0 && sb.expq.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
